// ===== hdl/addressable_led_frame_encoder_macros.svh =====
// assertion helpers used by the encoder
`ifndef ADDRESSABLE_LED_FRAME_ENCODER_MACROS_SVH
`define ADDRESSABLE_LED_FRAME_ENCODER_MACROS_SVH

// same-cycle implication
`define ALFE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alfe assertion failed");

// next-cycle implication
`define ALFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alfe assertion failed");

`endif

// ===== hdl/alfe_pkg.sv =====
`default_nettype none

package alfe_pkg;

   localparam int BITS_PER_LED = 24;
   localparam int BIT_CNT_W    = 5;
   localparam int TICK_W       = 15;
   localparam int CSR_IDX_W    = 3;

   localparam logic [1:0] MODE_SET  = 2'd0;
   localparam logic [1:0] MODE_FILL = 2'd1;
   localparam logic [1:0] MODE_EMIT = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_LED_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ORDER      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_HIGH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_HIGH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_LOW   = 3'd5;

   localparam logic [TICK_W-1:0] ONE_HIGH_RESET  = 15'd8;
   localparam logic [TICK_W-1:0] ONE_LOW_RESET   = 15'd4;
   localparam logic [TICK_W-1:0] ZERO_HIGH_RESET = 15'd4;
   localparam logic [TICK_W-1:0] ZERO_LOW_RESET  = 15'd8;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_LOAD,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      logic load;
   } ser_ctrl_type;

   typedef struct packed {
      logic bit_value;
      logic last;
      logic active;
   } ser_status_type;

endpackage

`default_nettype wire

// ===== hdl/addressable_led_frame_encoder.sv =====
// channel   | ports                      | handshake
// ----------+----------------------------+-----------------------------------
// request   | req_*                      | taken when start high, busy low
// response  | rsp_*                      | one cycle wide, marked by rsp_strobe
// registers | csr_index, csr_data        | written when csr_valid and csr_ready
//
// set, mode 3, zero fill count, overruns: busy only in exec, response in the next cycle
// fill in range: busy through exec and the fill state, one store entry written per cycle
// emit in range: store read in exec, serializer load, then 24 pulse responses one per cycle
// after reset a clearing pass zeroes all MAX_LEDS store entries, one entry a cycle,
// with busy high; register writes are taken throughout
// responses cannot be stalled, csr_ready is always high
`default_nettype none

module addressable_led_frame_encoder #(
   parameter int MAX_LEDS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_mode,
   input  wire logic [9:0]                          req_address,
   input  wire logic [10:0]                         req_count,
   input  wire logic [7:0]                          req_red,
   input  wire logic [7:0]                          req_green,
   input  wire logic [7:0]                          req_blue,
   output logic                                     rsp_strobe,
   output logic                                     rsp_status,
   output logic                                     rsp_pulse_valid,
   output logic [alfe_pkg::TICK_W-1:0]              rsp_high_ticks,
   output logic [alfe_pkg::TICK_W-1:0]              rsp_low_ticks,
   output logic                                     rsp_last,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [alfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [alfe_pkg::TICK_W-1:0]         csr_data
);

`include "addressable_led_frame_encoder_macros.svh"

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam logic [16:0] MAX_WIDE = 17'(MAX_LEDS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);
   localparam int WORD_W = alfe_pkg::BITS_PER_LED;

   // configuration registers
   logic [10:0]                  led_count_ff;
   logic                         order_ff;
   logic [alfe_pkg::TICK_W-1:0]  one_high_ff, one_low_ff, zero_high_ff, zero_low_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff <= '0;
         order_ff     <= 1'b0;
         one_high_ff  <= alfe_pkg::ONE_HIGH_RESET;
         one_low_ff   <= alfe_pkg::ONE_LOW_RESET;
         zero_high_ff <= alfe_pkg::ZERO_HIGH_RESET;
         zero_low_ff  <= alfe_pkg::ZERO_LOW_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            alfe_pkg::REG_LED_COUNT: led_count_ff <= csr_data[10:0];
            alfe_pkg::REG_ORDER:     order_ff     <= csr_data[0];
            alfe_pkg::REG_ONE_HIGH:  one_high_ff  <= csr_data;
            alfe_pkg::REG_ONE_LOW:   one_low_ff   <= csr_data;
            alfe_pkg::REG_ZERO_HIGH: zero_high_ff <= csr_data;
            alfe_pkg::REG_ZERO_LOW:  zero_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // usable led count
   logic [10:0] limit;
   always_comb begin
      if ({6'b0, led_count_ff} > MAX_WIDE) begin
         limit = 11'(MAX_LEDS);
      end else begin
         limit = led_count_ff;
      end
   end

   alfe_pkg::state_type state_ff, state_in;

   logic [1:0]           mode_ff, mode_in;
   logic [9:0]           addr_ff, addr_in;
   logic [10:0]          count_ff, count_in;
   logic [7:0]           red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic [AW-1:0]        walk_addr_ff, walk_addr_in;
   logic [10:0]          left_ff, left_in;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_status_ff, rsp_status_in;
   logic                          rsp_pv_ff, rsp_pv_in;
   logic [alfe_pkg::TICK_W-1:0]   rsp_high_ff, rsp_high_in, rsp_low_ff, rsp_low_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WORD_W-1:0]    wr_data, rd_data, packed_word;
   logic [11:0]          fill_end;
   logic                 single_oor, fill_oor;

   alfe_pkg::ser_ctrl_type   ser_ctrl;
   alfe_pkg::ser_status_type ser_status;

   assign busy = (state_ff != alfe_pkg::ST_IDLE);

   always_comb begin
      if (order_ff) begin
         packed_word = {green_ff, red_ff, blue_ff};
      end else begin
         packed_word = {red_ff, green_ff, blue_ff};
      end
      fill_end   = {2'b0, addr_ff} + {1'b0, count_ff};
      single_oor = ({1'b0, addr_ff} >= limit);
      fill_oor   = (fill_end > {1'b0, limit});
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      red_in        = red_ff;
      green_in      = green_ff;
      blue_in       = blue_ff;
      walk_addr_in  = walk_addr_ff;
      left_in       = left_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = 1'b0;
      rsp_pv_in     = 1'b0;
      rsp_high_in   = '0;
      rsp_low_in    = '0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = walk_addr_ff;
      wr_data       = packed_word;
      rd_en         = 1'b0;
      rd_addr       = AW'(addr_ff);
      ser_ctrl.load = 1'b0;

      unique case (state_ff)
         alfe_pkg::ST_CLEAR: begin
            wr_en        = 1'b1;
            wr_data      = '0;
            walk_addr_in = walk_addr_ff + 1'b1;
            if (walk_addr_ff == LAST_ADDR) begin
               state_in = alfe_pkg::ST_IDLE;
            end
         end
         alfe_pkg::ST_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               addr_in  = req_address;
               count_in = req_count;
               red_in   = req_red;
               green_in = req_green;
               blue_in  = req_blue;
               state_in = alfe_pkg::ST_EXEC;
            end
         end
         alfe_pkg::ST_EXEC: begin
            state_in = alfe_pkg::ST_IDLE;
            unique case (mode_ff)
               alfe_pkg::MODE_SET: begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = single_oor;
                  wr_en         = !single_oor;
                  wr_addr       = AW'(addr_ff);
               end
               alfe_pkg::MODE_FILL: begin
                  if (fill_oor || (count_ff == '0)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = fill_oor;
                  end else begin
                     walk_addr_in = AW'(addr_ff);
                     left_in      = count_ff;
                     state_in     = alfe_pkg::ST_FILL;
                  end
               end
               alfe_pkg::MODE_EMIT: begin
                  if (single_oor) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     state_in = alfe_pkg::ST_LOAD;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end
         alfe_pkg::ST_FILL: begin
            wr_en        = 1'b1;
            walk_addr_in = walk_addr_ff + 1'b1;
            left_in      = left_ff - 1'b1;
            if (left_ff == 11'd1) begin
               rsp_strobe_in = 1'b1;
               state_in      = alfe_pkg::ST_IDLE;
            end
         end
         alfe_pkg::ST_LOAD: begin
            ser_ctrl.load = 1'b1;
            state_in      = alfe_pkg::ST_SHIFT;
         end
         alfe_pkg::ST_SHIFT: begin
            rsp_strobe_in = 1'b1;
            rsp_pv_in     = 1'b1;
            rsp_last_in   = ser_status.last;
            if (ser_status.bit_value) begin
               rsp_high_in = one_high_ff;
               rsp_low_in  = one_low_ff;
            end else begin
               rsp_high_in = zero_high_ff;
               rsp_low_in  = zero_low_ff;
            end
            if (ser_status.last) begin
               state_in = alfe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = alfe_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= alfe_pkg::ST_CLEAR;
         walk_addr_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         walk_addr_ff  <= walk_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      count_ff      <= count_in;
      red_ff        <= red_in;
      green_ff      <= green_in;
      blue_ff       <= blue_in;
      left_ff       <= left_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pv_ff     <= rsp_pv_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_pulse_valid = rsp_pv_ff;
   assign rsp_high_ticks  = rsp_high_ff;
   assign rsp_low_ticks   = rsp_low_ff;
   assign rsp_last        = rsp_last_ff;

   alfe_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_LEDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   alfe_serial u_serial (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ser_ctrl),
      .word   (rd_data),
      .status (ser_status)
   );

   `ALFE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ALFE_ASSERT_NOW(a_no_write_emit, clock, reset,
      (state_ff == alfe_pkg::ST_LOAD) || (state_ff == alfe_pkg::ST_SHIFT), !wr_en)
   `ALFE_ASSERT_NEXT(a_last_pulse, clock, reset, ser_status.last,
      rsp_strobe && rsp_last && rsp_pulse_valid)
   `ALFE_ASSERT_NOW(a_shift_active, clock, reset,
      state_ff == alfe_pkg::ST_SHIFT, ser_status.active)

endmodule

`default_nettype wire

// ===== hdl/alfe_ram.sv =====
`default_nettype none

module alfe_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/alfe_serial.sv =====
`default_nettype none

module alfe_serial (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire alfe_pkg::ser_ctrl_type                    ctrl,
   input  wire logic [alfe_pkg::BITS_PER_LED-1:0]         word,
   output alfe_pkg::ser_status_type                       status
);

   localparam logic [alfe_pkg::BIT_CNT_W-1:0] LAST_BIT =
      alfe_pkg::BIT_CNT_W'(alfe_pkg::BITS_PER_LED - 1);

   logic [alfe_pkg::BITS_PER_LED-1:0] shift_ff, shift_in;
   logic [alfe_pkg::BIT_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              active_ff, active_in;

   always_comb begin
      shift_in  = shift_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      if (ctrl.load) begin
         shift_in  = word;
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         shift_in  = {shift_ff[alfe_pkg::BITS_PER_LED-2:0], 1'b0};
         cnt_in    = cnt_ff + 1'b1;
         active_in = (cnt_ff != LAST_BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         cnt_ff    <= cnt_in;
      end
      shift_ff <= shift_in;
   end

   always_comb begin
      status.bit_value = shift_ff[alfe_pkg::BITS_PER_LED-1];
      status.last      = active_ff && (cnt_ff == LAST_BIT);
      status.active    = active_ff;
   end

endmodule

`default_nettype wire
